// ===== rtl/wph_pkg.sv =====
// wph_pkg: shared types, codes and constants of the WAV/PCM header parser.
// No dependencies; used by wph_step, wav_pcm_header_parser and the testbench files.
`default_nettype none

package wph_pkg;

   // Parse phases
   localparam logic [2:0] PH_RIFF = 3'd0;
   localparam logic [2:0] PH_HDR  = 3'd1;
   localparam logic [2:0] PH_FMT  = 3'd2;
   localparam logic [2:0] PH_SKIP = 3'd3;
   localparam logic [2:0] PH_DATA = 3'd4;

   // Status codes on rsp_parse_status
   localparam logic [2:0] ST_HEADER = 3'd0;
   localparam logic [2:0] ST_DATA   = 3'd1;
   localparam logic [2:0] ST_NOTWAV = 3'd2;
   localparam logic [2:0] ST_UNSUP  = 3'd3;
   localparam logic [2:0] ST_IO     = 3'd4;

   // Chunk tags, big-endian as shifted in
   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   localparam int unsigned MAX_FORMAT_BYTES_DEFAULT = 40;
   localparam logic [31:0] MIN_FORMAT_BYTES = 32'd16;
   localparam logic [15:0] FORMAT_TAG_PCM   = 16'd1;

   // Configuration register indexes
   localparam logic [1:0] CSR_SAMPLE_RATE = 2'd0;
   localparam logic [1:0] CSR_CHANNELS    = 2'd1;
   localparam logic [1:0] CSR_SAMPLE_BITS = 2'd2;

   localparam logic [31:0] RESET_SAMPLE_RATE = 32'd16000;
   localparam logic [15:0] RESET_CHANNELS    = 16'd1;
   localparam logic [15:0] RESET_SAMPLE_BITS = 16'd16;

   typedef struct packed {
      logic [2:0]  phase;
      logic [5:0]  byte_index;
      logic [31:0] chunk_tag;
      logic [31:0] chunk_length;
      logic [31:0] field_value;
      logic        format_mismatch;
      logic        fmt_seen;
      logic        pad_pending;
      logic [31:0] data_left;
      logic [2:0]  error_code;
   } parser_state_type;

   typedef struct packed {
      logic [31:0] sample_rate;
      logic [15:0] channels;
      logic [15:0] sample_bits;
   } format_cfg_type;

   typedef struct packed {
      logic [2:0] parse_status;
      logic [7:0] sample_byte;
      logic       sample_valid;
      logic       last_sample;
   } parse_result_type;

   localparam parser_state_type STATE_RESET = '{
      phase:           PH_RIFF,
      byte_index:      6'd0,
      chunk_tag:       32'd0,
      chunk_length:    32'd0,
      field_value:     32'd0,
      format_mismatch: 1'b0,
      fmt_seen:        1'b0,
      pad_pending:     1'b0,
      data_left:       32'd0,
      error_code:      ST_HEADER
   };

endpackage

`default_nettype wire

// ===== rtl/wav_pcm_header_parser.sv =====
// wav_pcm_header_parser: RIFF/WAVE header check and PCM data pass-through, top level.
// Depends on wph_pkg and wph_step.
`default_nettype none

// Channel  Direction  Ports                                        Beat
// req      in         req_valid/req_stall, stream byte, end mark   one file byte
// rsp      out        rsp_valid/rsp_stall, status, sample, flags   one result per req beat
// csr      in         csr_write_enable, csr_index, csr_write_data  one register write
//
// One req beat is taken per cycle unless req_stall is high; its result is in the rsp
// register on the next cycle. The rate is set by the single parse step between
// the state registers and the result register: one byte per cycle while rsp is not stalled.
// A full rsp register that is stalled stalls req in the same cycle.
// Reset is synchronous: parser back to the RIFF preamble, registers to
// 16000 Hz, 1 channel, 16 bits, rsp empty.

module wav_pcm_header_parser #(
   parameter int unsigned MAX_FORMAT_BYTES = wph_pkg::MAX_FORMAT_BYTES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_stream_byte,
   input  wire logic        req_end_of_stream,

   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [2:0]  rsp_parse_status,
   output      logic [7:0]  rsp_sample_byte,
   output      logic        rsp_sample_valid,
   output      logic        rsp_last_sample,

   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_write_data
);

   wph_pkg::parser_state_type state_ff;
   wph_pkg::parser_state_type state_in;
   wph_pkg::format_cfg_type   cfg_ff;
   wph_pkg::parse_result_type result_in;
   wph_pkg::parse_result_type result_ff;
   logic                      rsp_valid_ff;
   logic                      req_take;

   // result register frees up when empty or drained this cycle
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;

   wph_step #(
      .MAX_FORMAT_BYTES (MAX_FORMAT_BYTES)
   ) u_step (
      .cur           (state_ff),
      .cfg           (cfg_ff),
      .stream_byte   (req_stream_byte),
      .end_of_stream (req_end_of_stream),
      .nxt           (state_in),
      .res           (result_in)
   );

   // parser state advances once per accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wph_pkg::STATE_RESET;
      end else if (req_take) begin
         state_ff <= state_in;
      end
   end

   // expected format registers; index 3 is ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_rate <= wph_pkg::RESET_SAMPLE_RATE;
         cfg_ff.channels    <= wph_pkg::RESET_CHANNELS;
         cfg_ff.sample_bits <= wph_pkg::RESET_SAMPLE_BITS;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            wph_pkg::CSR_SAMPLE_RATE: cfg_ff.sample_rate <= csr_write_data;
            wph_pkg::CSR_CHANNELS:    cfg_ff.channels    <= csr_write_data[15:0];
            wph_pkg::CSR_SAMPLE_BITS: cfg_ff.sample_bits <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   // result register: loads on accept, empties when taken without a new beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_parse_status = result_ff.parse_status;
   assign rsp_sample_byte  = result_ff.sample_byte;
   assign rsp_sample_valid = result_ff.sample_valid;
   assign rsp_last_sample  = result_ff.last_sample;

endmodule

`default_nettype wire

// ===== rtl/wph_step.sv =====
// wph_step: next-state and result logic for one file byte of the parser.
// Depends on wph_pkg.
`default_nettype none

module wph_step #(
   parameter int unsigned MAX_FORMAT_BYTES = wph_pkg::MAX_FORMAT_BYTES_DEFAULT
) (
   input  wire wph_pkg::parser_state_type cur,
   input  wire wph_pkg::format_cfg_type   cfg,
   input  wire logic [7:0]                stream_byte,
   input  wire logic                      end_of_stream,
   output wph_pkg::parser_state_type      nxt,
   output wph_pkg::parse_result_type      res
);

   logic [31:0] len_new;
   logic [31:0] fv_new;
   logic [15:0] half;
   logic        mism_new;
   logic        fmt_last;
   logic [31:0] skip_len;

   always_comb begin
      nxt      = cur;
      res      = '0;
      len_new  = cur.chunk_length;
      fv_new   = {stream_byte, cur.field_value[31:8]};
      half     = fv_new[31:16];
      mism_new = cur.format_mismatch;
      fmt_last = (32'({26'd0, cur.byte_index}) + 32'd1) >= cur.chunk_length;
      skip_len = cur.chunk_length;

      if (cur.error_code == wph_pkg::ST_HEADER) begin
         if (end_of_stream) begin
            if (cur.phase == wph_pkg::PH_FMT) begin
               nxt.error_code = wph_pkg::ST_IO;
            end else if (cur.phase == wph_pkg::PH_DATA) begin
               if (cur.data_left != 32'd0) begin
                  nxt.error_code = wph_pkg::ST_IO;
               end
            end else begin
               nxt.error_code = wph_pkg::ST_NOTWAV;
            end
         end else begin
            unique case (cur.phase)
               wph_pkg::PH_RIFF: begin
                  nxt.chunk_tag = {cur.chunk_tag[23:0], stream_byte};
                  if (cur.byte_index == 6'd3 && nxt.chunk_tag != wph_pkg::TAG_RIFF) begin
                     nxt.error_code = wph_pkg::ST_NOTWAV;
                  end else if (cur.byte_index == 6'd11) begin
                     if (nxt.chunk_tag != wph_pkg::TAG_WAVE) begin
                        nxt.error_code = wph_pkg::ST_NOTWAV;
                     end else begin
                        nxt.phase      = wph_pkg::PH_HDR;
                        nxt.byte_index = 6'd0;
                     end
                  end else begin
                     nxt.byte_index = cur.byte_index + 6'd1;
                  end
               end

               wph_pkg::PH_HDR: begin
                  // tag big-endian, length little-endian
                  case (cur.byte_index[2:0])
                     3'd4:    len_new = {24'd0, stream_byte};
                     3'd5:    len_new[15:8]  = stream_byte;
                     3'd6:    len_new[23:16] = stream_byte;
                     3'd7:    len_new[31:24] = stream_byte;
                     default: nxt.chunk_tag  = {cur.chunk_tag[23:0], stream_byte};
                  endcase
                  nxt.chunk_length = len_new;
                  if (cur.byte_index[2:0] == 3'd7) begin
                     if (cur.chunk_tag == wph_pkg::TAG_FMT) begin
                        if (len_new < wph_pkg::MIN_FORMAT_BYTES ||
                            len_new > 32'(MAX_FORMAT_BYTES)) begin
                           nxt.error_code = wph_pkg::ST_UNSUP;
                        end else begin
                           nxt.format_mismatch = 1'b0;
                           nxt.field_value     = 32'd0;
                           nxt.byte_index      = 6'd0;
                           nxt.phase           = wph_pkg::PH_FMT;
                        end
                     end else if (cur.chunk_tag == wph_pkg::TAG_DATA) begin
                        if (!cur.fmt_seen) begin
                           nxt.error_code = wph_pkg::ST_NOTWAV;
                        end else begin
                           nxt.data_left = len_new;
                           nxt.phase     = wph_pkg::PH_DATA;
                        end
                     end else begin
                        nxt.pad_pending = len_new[0];
                        nxt.byte_index  = 6'd0;
                        nxt.phase = (len_new == 32'd0) ? wph_pkg::PH_HDR : wph_pkg::PH_SKIP;
                     end
                  end else begin
                     nxt.byte_index = {3'd0, cur.byte_index[2:0] + 3'd1};
                  end
               end

               wph_pkg::PH_FMT: begin
                  // fields land in the top half once their last byte is in
                  if (cur.byte_index == 6'd1 && half != wph_pkg::FORMAT_TAG_PCM)
                     mism_new = 1'b1;
                  if (cur.byte_index == 6'd3 && half != cfg.channels)
                     mism_new = 1'b1;
                  if (cur.byte_index == 6'd7 && fv_new != cfg.sample_rate)
                     mism_new = 1'b1;
                  if (cur.byte_index == 6'd15 && half != cfg.sample_bits)
                     mism_new = 1'b1;
                  nxt.field_value     = fv_new;
                  nxt.format_mismatch = mism_new;
                  if (fmt_last) begin
                     if (mism_new) begin
                        nxt.error_code = wph_pkg::ST_UNSUP;
                     end else begin
                        nxt.fmt_seen     = 1'b1;
                        nxt.byte_index   = 6'd0;
                        nxt.chunk_length = 32'd0;
                        // odd body length leaves a pad byte
                        nxt.pad_pending  = ~cur.byte_index[0];
                        nxt.phase = cur.byte_index[0] ? wph_pkg::PH_HDR : wph_pkg::PH_SKIP;
                     end
                  end else begin
                     nxt.byte_index = cur.byte_index + 6'd1;
                  end
               end

               wph_pkg::PH_SKIP: begin
                  if (cur.chunk_length != 32'd0) begin
                     skip_len = cur.chunk_length - 32'd1;
                  end else begin
                     nxt.pad_pending = 1'b0;
                  end
                  nxt.chunk_length = skip_len;
                  if (skip_len == 32'd0 && !nxt.pad_pending) begin
                     nxt.phase      = wph_pkg::PH_HDR;
                     nxt.byte_index = 6'd0;
                  end
               end

               wph_pkg::PH_DATA: begin
                  if (cur.data_left != 32'd0) begin
                     res.sample_byte  = stream_byte;
                     res.sample_valid = 1'b1;
                     res.last_sample  = (cur.data_left == 32'd1);
                     nxt.data_left    = cur.data_left - 32'd1;
                  end
               end

               default: nxt.phase = wph_pkg::PH_RIFF;
            endcase
         end
      end

      if (nxt.error_code != wph_pkg::ST_HEADER) begin
         res = '0;
         res.parse_status = nxt.error_code;
      end else begin
         res.parse_status = (nxt.phase == wph_pkg::PH_DATA) ? wph_pkg::ST_DATA
                                                            : wph_pkg::ST_HEADER;
      end
   end

endmodule

`default_nettype wire

// ===== tb/wph_result_checker.sv =====
// wph_result_checker: watches the req, rsp and csr ports of the WAV header parser,
// predicts one result per accepted req beat and compares each rsp beat with it.
// Depends on wph_pkg.
`timescale 1ns / 1ps

module wph_result_checker import wph_pkg::*; #(
   parameter int unsigned MAX_FORMAT_BYTES = MAX_FORMAT_BYTES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [7:0]  req_stream_byte,
   input  wire logic        req_end_of_stream,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [2:0]  rsp_parse_status,
   input  wire logic [7:0]  rsp_sample_byte,
   input  wire logic        rsp_sample_valid,
   input  wire logic        rsp_last_sample,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_write_data,
   output logic [31:0]      fail_count,
   output logic [31:0]      results_due
);

   // parser state as the predictor sees it
   logic [2:0]  phase;
   logic [5:0]  byte_idx;
   logic [31:0] tag_shift;
   logic [31:0] chunk_len;
   logic [31:0] fmt_word;
   logic        fmt_bad;
   logic        fmt_seen;
   logic        pad_due;
   logic [31:0] data_left;
   logic [2:0]  err_code;   // ST_HEADER (0) doubles as "no error"

   logic [31:0] want_rate;
   logic [15:0] want_channels;
   logic [15:0] want_bits;

   parse_result_type pending_parse_results[$];
   int unsigned      mismatches = 0;

   // One file byte through the parser; returns the result that beat must give.
   function automatic parse_result_type parse_next_byte(input logic [7:0] b, input logic eos);
      parse_result_type r;
      logic [2:0]  hidx;
      logic [5:0]  fidx;
      logic [15:0] half;
      r = '0;
      if (err_code == ST_HEADER) begin
         if (eos) begin
            if (phase == PH_FMT) err_code = ST_IO;
            else if (phase == PH_DATA) begin
               if (data_left != 0) err_code = ST_IO;
            end else err_code = ST_NOTWAV;
         end else begin
            case (phase)
               PH_RIFF: begin
                  tag_shift = {tag_shift[23:0], b};
                  if (byte_idx == 6'd3 && tag_shift != TAG_RIFF) err_code = ST_NOTWAV;
                  else if (byte_idx == 6'd11) begin
                     if (tag_shift != TAG_WAVE) err_code = ST_NOTWAV;
                     else begin
                        phase    = PH_HDR;
                        byte_idx = '0;
                     end
                  end else byte_idx = byte_idx + 6'd1;
               end
               PH_HDR: begin
                  hidx = byte_idx[2:0];
                  if (hidx < 3'd4) tag_shift = {tag_shift[23:0], b};
                  else if (hidx == 3'd4) chunk_len = {24'd0, b};
                  else chunk_len = chunk_len | ({24'd0, b} << (8 * (hidx - 4)));
                  if (hidx == 3'd7) begin
                     if (tag_shift == TAG_FMT) begin
                        if (chunk_len < MIN_FORMAT_BYTES || chunk_len > 32'(MAX_FORMAT_BYTES))
                           err_code = ST_UNSUP;
                        else begin
                           fmt_bad  = 1'b0;
                           fmt_word = '0;
                           byte_idx = '0;
                           phase    = PH_FMT;
                        end
                     end else if (tag_shift == TAG_DATA) begin
                        if (!fmt_seen) err_code = ST_NOTWAV;
                        else begin
                           data_left = chunk_len;
                           phase     = PH_DATA;
                        end
                     end else begin
                        pad_due  = chunk_len[0];
                        byte_idx = '0;
                        phase    = (chunk_len == 0) ? PH_HDR : PH_SKIP;
                     end
                  end else byte_idx = {3'd0, hidx} + 6'd1;
               end
               PH_FMT: begin
                  fidx     = byte_idx;
                  fmt_word = {b, fmt_word[31:8]};
                  half     = fmt_word[31:16];
                  if (fidx == 6'd1 && half != FORMAT_TAG_PCM) fmt_bad = 1'b1;
                  if (fidx == 6'd3 && half != want_channels) fmt_bad = 1'b1;
                  if (fidx == 6'd7 && fmt_word != want_rate) fmt_bad = 1'b1;
                  if (fidx == 6'd15 && half != want_bits) fmt_bad = 1'b1;
                  if ({26'd0, fidx} + 32'd1 >= chunk_len) begin
                     if (fmt_bad) err_code = ST_UNSUP;
                     else begin
                        fmt_seen  = 1'b1;
                        byte_idx  = '0;
                        chunk_len = '0;
                        pad_due   = ~fidx[0];   // odd body length leaves a pad byte
                        phase     = pad_due ? PH_SKIP : PH_HDR;
                     end
                  end else byte_idx = fidx + 6'd1;
               end
               PH_SKIP: begin
                  if (chunk_len != 0) chunk_len = chunk_len - 1;
                  else pad_due = 1'b0;
                  if (chunk_len == 0 && !pad_due) begin
                     phase    = PH_HDR;
                     byte_idx = '0;
                  end
               end
               PH_DATA: begin
                  if (data_left != 0) begin
                     r.sample_byte  = b;
                     r.sample_valid = 1'b1;
                     r.last_sample  = (data_left == 1);
                     data_left      = data_left - 1;
                  end
               end
               default: phase = PH_RIFF;
            endcase
         end
      end
      if (err_code != ST_HEADER) begin
         r = '0;
         r.parse_status = err_code;
      end else r.parse_status = (phase == PH_DATA) ? ST_DATA : ST_HEADER;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      parse_result_type got;
      parse_result_type want;
      if (reset) begin
         phase     = PH_RIFF;
         byte_idx  = '0;
         tag_shift = '0;
         chunk_len = '0;
         fmt_word  = '0;
         fmt_bad   = 1'b0;
         fmt_seen  = 1'b0;
         pad_due   = 1'b0;
         data_left = '0;
         err_code  = ST_HEADER;
         want_rate     = RESET_SAMPLE_RATE;
         want_channels = RESET_CHANNELS;
         want_bits     = RESET_SAMPLE_BITS;
         pending_parse_results.delete();
         mismatches = 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_SAMPLE_RATE: want_rate     = csr_write_data;
               CSR_CHANNELS:    want_channels = csr_write_data[15:0];
               CSR_SAMPLE_BITS: want_bits     = csr_write_data[15:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got.parse_status = rsp_parse_status;
            got.sample_byte  = rsp_sample_byte;
            got.sample_valid = rsp_sample_valid;
            got.last_sample  = rsp_last_sample;
            if (pending_parse_results.size() == 0) begin
               $error("rsp beat with no prediction waiting: parse_status %0d",
                      got.parse_status);
               mismatches++;
            end else begin
               want = pending_parse_results.pop_front();
               if (got.parse_status !== want.parse_status) begin
                  $error("parse_status: expected %0d, actual %0d",
                         want.parse_status, got.parse_status);
                  mismatches++;
               end
               if (got.sample_byte !== want.sample_byte) begin
                  $error("sample_byte: expected 0x%02h, actual 0x%02h",
                         want.sample_byte, got.sample_byte);
                  mismatches++;
               end
               if (got.sample_valid !== want.sample_valid) begin
                  $error("sample_valid: expected %0d, actual %0d",
                         want.sample_valid, got.sample_valid);
                  mismatches++;
               end
               if (got.last_sample !== want.last_sample) begin
                  $error("last_sample: expected %0d, actual %0d",
                         want.last_sample, got.last_sample);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall)
            pending_parse_results.push_back(parse_next_byte(req_stream_byte, req_end_of_stream));
      end
      fail_count  <= mismatches;
      results_due <= pending_parse_results.size();
   end

endmodule

// ===== tb/wav_pcm_header_parser_tb.sv =====
// wav_pcm_header_parser_tb: clock, reset, file-byte stimulus, register writes and verdict.
// Depends on wph_pkg, wph_result_checker and the wav_pcm_header_parser RTL.
`timescale 1ns / 1ps

module wav_pcm_header_parser_tb;
   import wph_pkg::*;

   // Generous cap on the run, in cycles, for the worst stall mix.
   localparam int unsigned RUN_LIMIT = 200_000;
   localparam int unsigned MAX_FMT   = MAX_FORMAT_BYTES_DEFAULT;
   localparam logic [1:0]  CSR_SPARE = 2'd3;            // no register behind it
   localparam logic [31:0] TAG_LIST  = 32'h4C49_5354;   // an ordinary chunk tag

   // How the one file of this run finishes. Errors are sticky and reset is
   // applied once only, so each seed lands on one of these endings.
   typedef enum logic [3:0] {
      END_BAD_RIFF, END_BAD_WAVE, END_DATA_FIRST, END_DATA, END_DATA_SHORT,
      END_EOS_HDR, END_EOS_SKIP, END_EOS_PAD, END_EOS_FMT, END_FMT_SHORT,
      END_FMT_LONG, END_BAD_TAG, END_BAD_CHANNELS, END_BAD_RATE, END_BAD_BITS
   } ending_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_stream_byte = 8'd0;
   logic        req_end_of_stream = 1'b0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_parse_status;
   logic [7:0]  rsp_sample_byte;
   logic        rsp_sample_valid;
   logic        rsp_last_sample;

   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = CSR_SAMPLE_RATE;
   logic [31:0] csr_write_data = 32'd0;

   logic [31:0] check_failures;
   logic [31:0] results_due;

   // stimulus side bookkeeping
   int unsigned send_idle_pct  = 17;
   int unsigned recv_stall_pct = 85;
   int unsigned beats_sent     = 0;
   int unsigned cycle_count    = 0;
   logic [31:0] cfg_rate     = RESET_SAMPLE_RATE;
   logic [15:0] cfg_channels = RESET_CHANNELS;
   logic [15:0] cfg_bits     = RESET_SAMPLE_BITS;
   ending_kind_type ending;

   wav_pcm_header_parser dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_stream_byte   (req_stream_byte),
      .req_end_of_stream (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_parse_status  (rsp_parse_status),
      .rsp_sample_byte   (rsp_sample_byte),
      .rsp_sample_valid  (rsp_sample_valid),
      .rsp_last_sample   (rsp_last_sample),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   wph_result_checker #(.MAX_FORMAT_BYTES(MAX_FMT)) result_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_stream_byte   (req_stream_byte),
      .req_end_of_stream (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_parse_status  (rsp_parse_status),
      .rsp_sample_byte   (rsp_sample_byte),
      .rsp_sample_valid  (rsp_sample_valid),
      .rsp_last_sample   (rsp_last_sample),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .fail_count        (check_failures),
      .results_due       (results_due)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Receiver: random stall at the current rate.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // One req beat. Called at a rising edge; returns at the edge that took it,
   // leaving valid high so back-to-back beats never drop it in between.
   task automatic send_beat(input logic [7:0] b, input logic eos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_stream_byte   <= b;
      req_end_of_stream <= eos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
   endtask

   // Chunk header: tag in file order, then the length little-endian.
   task automatic send_chunk_header(input logic [31:0] tag, input logic [31:0] len);
      for (int i = 3; i >= 0; i--) send_beat(tag[8*i +: 8], 1'b0);
      for (int i = 0; i < 4; i++) send_beat(len[8*i +: 8], 1'b0);
   endtask

   // fmt chunk with the first body_bytes of its body; the checked fields sit at
   // fixed offsets, everything else (byte rate, block align, extension) is noise.
   task automatic send_fmt_chunk(input logic [31:0] len, input logic [15:0] fmt_tag,
                                 input logic [15:0] ch, input logic [31:0] rate,
                                 input logic [15:0] bits, input int body_bytes);
      logic [7:0] v;
      send_chunk_header(TAG_FMT, len);
      for (int i = 0; i < body_bytes; i++) begin
         case (i)
            0:       v = fmt_tag[7:0];
            1:       v = fmt_tag[15:8];
            2:       v = ch[7:0];
            3:       v = ch[15:8];
            4:       v = rate[7:0];
            5:       v = rate[15:8];
            6:       v = rate[23:16];
            7:       v = rate[31:24];
            14:      v = bits[7:0];
            15:      v = bits[15:8];
            default: v = 8'($urandom_range(255));
         endcase
         send_beat(v, 1'b0);
      end
   endtask

   // A complete fmt chunk matching the registers, pad byte included.
   task automatic send_good_fmt(input int len);
      send_fmt_chunk(len, FORMAT_TAG_PCM, cfg_channels, cfg_rate, cfg_bits, len);
      if (len % 2 == 1) send_beat(8'($urandom_range(255)), 1'b0);
   endtask

   // Unknown chunk. The tag is random, sometimes one bit away from fmt or data.
   task automatic send_skip_chunk(input logic [31:0] len, input int body_bytes,
                                  input logic with_pad);
      logic [31:0] t;
      t = $urandom;
      if ($urandom_range(3) == 0)
         t = ($urandom_range(1) ? TAG_FMT : TAG_DATA) ^ (32'd1 << $urandom_range(31));
      else if (t == TAG_FMT || t == TAG_DATA) t[0] = ~t[0];
      send_chunk_header(t, len);
      repeat (body_bytes) send_beat(8'($urandom_range(255)), 1'b0);
      if (with_pad && len[0]) send_beat(8'($urandom_range(255)), 1'b0);
   endtask

   // Random bytes and end marks; by this point the parser ignores them.
   task automatic send_noise(input int n);
      repeat (n) send_beat(8'($urandom_range(255)), $urandom_range(3) == 0);
   endtask

   // Stop sending and wait for every predicted rsp beat to be out.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // All three format registers, junk in the unused upper halves, plus a
   // write to the spare index that must change nothing.
   task automatic program_format(input logic [31:0] rate, input logic [15:0] ch,
                                 input logic [15:0] bits);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_SAMPLE_RATE;
      csr_write_data   <= rate;
      @(posedge clock);
      csr_index      <= CSR_CHANNELS;
      csr_write_data <= {16'($urandom), ch};
      @(posedge clock);
      csr_index      <= CSR_SAMPLE_BITS;
      csr_write_data <= {16'($urandom), bits};
      @(posedge clock);
      csr_index      <= CSR_SPARE;
      csr_write_data <= $urandom;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_rate     = rate;
      cfg_channels = ch;
      cfg_bits     = bits;
   endtask

   initial begin
      int          r;
      int          k;
      logic [31:0] len;
      logic [31:0] rnd_rate;
      logic [15:0] m16;
      logic [31:0] m32;
      logic [7:0]  preamble [12];

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      r = $urandom_range(99);
      if (r < 2)       ending = END_BAD_RIFF;
      else if (r < 4)  ending = END_BAD_WAVE;
      else if (r < 6)  ending = END_DATA_FIRST;
      else if (r < 42) ending = END_DATA;
      else if (r < 48) ending = END_DATA_SHORT;
      else if (r < 53) ending = END_EOS_HDR;
      else if (r < 58) ending = END_EOS_SKIP;
      else if (r < 63) ending = END_EOS_PAD;
      else if (r < 68) ending = END_EOS_FMT;
      else if (r < 74) ending = END_FMT_SHORT;
      else if (r < 80) ending = END_FMT_LONG;
      else if (r < 85) ending = END_BAD_TAG;
      else if (r < 90) ending = END_BAD_CHANNELS;
      else if (r < 95) ending = END_BAD_RATE;
      else             ending = END_BAD_BITS;

      // ---- directed: preamble, then a one-byte chunk with 00 body and FF pad ----
      for (int i = 0; i < 4; i++) begin
         preamble[i]     = TAG_RIFF[31 - 8*i -: 8];
         preamble[4 + i] = 8'($urandom_range(255));   // RIFF length, not checked
         preamble[8 + i] = TAG_WAVE[31 - 8*i -: 8];
      end
      if (ending == END_BAD_RIFF)
         preamble[$urandom_range(3)] ^= 8'(1 << $urandom_range(7));
      if (ending == END_BAD_WAVE)
         preamble[$urandom_range(11, 8)] ^= 8'(1 << $urandom_range(7));
      for (int i = 0; i < 12; i++) send_beat(preamble[i], 1'b0);
      send_chunk_header(TAG_LIST, 32'd1);
      send_beat(8'h00, 1'b0);
      send_beat(8'hFF, 1'b0);

      if (ending == END_BAD_RIFF || ending == END_BAD_WAVE || ending == END_DATA_FIRST) begin
         // data chunk before any fmt chunk is rejected when its header completes
         if (ending == END_DATA_FIRST) send_chunk_header(TAG_DATA, $urandom_range(20));
         // the error is sticky: the rest of the run is ignored bytes, under each idling mix
         for (int seg = 0; seg < 3; seg++) begin
            if (seg == 1) begin
               send_idle_pct = 85;
               recv_stall_pct <= 17;
            end
            if (seg == 2) begin
               send_idle_pct = 0;
               recv_stall_pct <= 0;
            end
            while (beats_sent < 22 + (seg + 1) * 276) send_noise(1);
         end
      end else begin
         // ---- random body: four register settings over three idling regimes ----
         for (int seg = 0; seg < 4; seg++) begin
            if (seg > 0) begin
               wait_drained();
               case (seg)
                  1: program_format(32'd0, 16'd0, 16'd0);
                  2: program_format(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
                  default: begin
                     case ($urandom_range(3))
                        0:       rnd_rate = 32'd8000;
                        1:       rnd_rate = 32'd44100;
                        2:       rnd_rate = 32'd48000;
                        default: rnd_rate = $urandom;
                     endcase
                     program_format(rnd_rate, 16'($urandom_range(8, 1)),
                                    16'(8 * $urandom_range(4, 1)));
                  end
               endcase
            end
            if (seg == 2) begin
               send_idle_pct = 85;
               recv_stall_pct <= 17;
            end
            if (seg == 3) begin
               send_idle_pct = 0;
               recv_stall_pct <= 0;
            end
            // open each segment with a fmt chunk under the new settings
            send_good_fmt(seg == 0 ? 16 : (seg == 1 ? int'(MAX_FMT) : $urandom_range(MAX_FMT, 16)));
            while (beats_sent < 22 + (seg + 1) * 205) begin
               if ($urandom_range(99) < 45) begin
                  if ($urandom_range(7) == 0) send_good_fmt($urandom_range(1) ? 16 : MAX_FMT);
                  else send_good_fmt($urandom_range(MAX_FMT, 16));
               end else begin
                  len = ($urandom_range(99) < 30) ? 32'd0 : 32'($urandom_range(24, 1));
                  send_skip_chunk(len, len, 1'b1);
               end
            end
         end

         // ---- the ending picked above; the parser is at a chunk boundary here ----
         case (ending)
            END_DATA: begin
               r = $urandom_range(9);
               len = (r == 0) ? 32'd0 : ((r == 1) ? 32'd1 : 32'($urandom_range(96, 2)));
               send_chunk_header(TAG_DATA, len);
               repeat (len) send_beat(8'($urandom_range(255)), 1'b0);
            end
            END_DATA_SHORT: begin
               len = $urandom_range(64, 2);
               send_chunk_header(TAG_DATA, len);
               repeat ($urandom_range(len - 1, 0)) send_beat(8'($urandom_range(255)), 1'b0);
               send_beat(8'($urandom_range(255)), 1'b1);
            end
            END_EOS_HDR: begin
               repeat ($urandom_range(7)) send_beat(8'($urandom_range(255)), 1'b0);
               send_beat(8'($urandom_range(255)), 1'b1);
            end
            END_EOS_SKIP: begin
               len = $urandom_range(1) ? $urandom : 32'($urandom_range(30, 2));
               if (len < 2) len = 32'd2;
               k = (len > 31) ? $urandom_range(30) : $urandom_range(len - 1, 0);
               send_skip_chunk(len, k, 1'b0);
               send_beat(8'($urandom_range(255)), 1'b1);
            end
            END_EOS_PAD: begin
               // end mark where the pad byte of an odd-length chunk belongs
               if ($urandom_range(1)) begin
                  len = 2 * $urandom_range(11) + 1;
                  send_skip_chunk(len, len, 1'b0);
               end else begin
                  len = 2 * $urandom_range(11, 8) + 1;
                  send_fmt_chunk(len, FORMAT_TAG_PCM, cfg_channels, cfg_rate, cfg_bits, len);
               end
               send_beat(8'($urandom_range(255)), 1'b1);
            end
            END_EOS_FMT: begin
               len = $urandom_range(MAX_FMT, 16);
               send_fmt_chunk(len, FORMAT_TAG_PCM, cfg_channels, cfg_rate, cfg_bits,
                              $urandom_range(len - 1, 0));
               send_beat(8'($urandom_range(255)), 1'b1);
            end
            END_FMT_SHORT: send_chunk_header(TAG_FMT, $urandom_range(15));
            END_FMT_LONG: begin
               r = $urandom_range(2);
               if (r == 0) len = MAX_FMT + 1;
               else if (r == 1) len = 32'hFFFF_FFFF;
               else len = $urandom | 32'h80;
               send_chunk_header(TAG_FMT, len);
            end
            default: begin
               // one checked fmt field off by a nonzero mask; flagged on the last byte
               len = $urandom_range(MAX_FMT, 16);
               m16 = $urandom_range(65535, 1);
               m32 = $urandom;
               if (m32 == 0) m32 = 32'd1;
               case (ending)
                  END_BAD_TAG:
                     send_fmt_chunk(len, FORMAT_TAG_PCM ^ m16, cfg_channels, cfg_rate,
                                    cfg_bits, len);
                  END_BAD_CHANNELS:
                     send_fmt_chunk(len, FORMAT_TAG_PCM, cfg_channels ^ m16, cfg_rate,
                                    cfg_bits, len);
                  END_BAD_RATE:
                     send_fmt_chunk(len, FORMAT_TAG_PCM, cfg_channels, cfg_rate ^ m32,
                                    cfg_bits, len);
                  default:
                     send_fmt_chunk(len, FORMAT_TAG_PCM, cfg_channels, cfg_rate,
                                    cfg_bits ^ m16, len);
               endcase
            end
         endcase
         // after the data chunk or a sticky error everything is ignored
         send_noise(30);
      end

      wait_drained();
      if (check_failures == 0 && results_due == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== wav_pcm_header_parser.f =====
rtl/wph_pkg.sv
rtl/wph_step.sv
rtl/wav_pcm_header_parser.sv
tb/wph_result_checker.sv
tb/wav_pcm_header_parser_tb.sv
